@@ rtl/core/scm_pkg.sv @@
// Shared constants, types and helpers for the serial command state matcher.
package scm_pkg;

  localparam int LINE_LEN    = 64;
  localparam int TABLE_DEPTH = 32;
  localparam int EVENT_LEN   = 16;

  localparam int LINE_AW = $clog2(LINE_LEN);
  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int EV_AW   = $clog2(EVENT_LEN);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_HEADER  = 2'd1;
  localparam logic [1:0] CMD_CHAR    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_NO_TABLE = 2'd2;

  localparam logic REG_INIT_STATE  = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  // line buffer write/clear request
  typedef struct packed {
    logic       we;
    logic       clr;
    logic [7:0] data;
  } line_wr_t;

  // table write request
  typedef struct packed {
    logic              hdr_we;
    logic              chr_we;
    logic [TBL_AW-1:0] idx;
    logic [7:0]        state;
    logic [7:0]        next;
    logic [4:0]        len;
    logic [EV_AW-1:0]  cidx;
    logic [7:0]        cval;
  } tbl_wr_t;

  // table entry header as read back
  typedef struct packed {
    logic [7:0] state;
    logic [7:0] next;
    logic [4:0] len;
  } tbl_hdr_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

@@ rtl/core/scm_line_buf.sv @@
// Line store with write position and filled extent.
module scm_line_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scm_pkg::line_wr_t          wr,
  input  logic [scm_pkg::LINE_AW-1:0] raddr,
  output logic [7:0]                 rdata,
  output logic [scm_pkg::LINE_AW:0]  extent
);
  import scm_pkg::*;

  logic [7:0]         mem [LINE_LEN];
  logic [LINE_AW-1:0] wpos_r, wpos_nxt;
  logic [LINE_AW:0]   ext_r, ext_nxt;
  logic [7:0]         rdata_r;
  logic [LINE_AW:0]   wpos_inc;

  assign wpos_inc = {1'b0, wpos_r} + 1'b1;

  // advance position, track highest fill, clear on request
  always_comb begin
    wpos_nxt = wpos_r;
    ext_nxt  = ext_r;
    if (wr.clr) begin
      wpos_nxt = '0;
      ext_nxt  = '0;
    end else if (wr.we) begin
      wpos_nxt = (wpos_r == LINE_AW'(LINE_LEN - 1)) ? '0 : wpos_r + 1'b1;
      if (wpos_inc > ext_r) ext_nxt = wpos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      ext_r  <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      ext_r  <= ext_nxt;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.we && !wr.clr) mem[wpos_r] <= wr.data;
    rdata_r <= mem[raddr];
  end

  assign rdata  = rdata_r;
  assign extent = ext_r;
endmodule

@@ rtl/core/scm_table.sv @@
// Transition table: entry headers and event characters.
module scm_table (
  input  logic                                     clk,
  input  scm_pkg::tbl_wr_t                         wr,
  input  logic [scm_pkg::TBL_AW-1:0]               hdr_raddr,
  output scm_pkg::tbl_hdr_t                        hdr_rdata,
  input  logic [scm_pkg::TBL_AW+scm_pkg::EV_AW-1:0] chr_raddr,
  output logic [7:0]                               chr_rdata
);
  import scm_pkg::*;

  tbl_hdr_t   hdr_mem [TABLE_DEPTH];
  logic [7:0] chr_mem [TABLE_DEPTH*EVENT_LEN];
  tbl_hdr_t   hdr_r;
  logic [7:0] chr_r;
  logic [4:0] len_clamped;

  // clamp oversize event length
  assign len_clamped = (wr.len > 5'(EVENT_LEN)) ? 5'(EVENT_LEN) : wr.len;

  always_ff @(posedge clk) begin
    if (wr.hdr_we) hdr_mem[wr.idx] <= '{state: wr.state, next: wr.next, len: len_clamped};
    if (wr.chr_we) chr_mem[{wr.idx, wr.cidx}] <= wr.cval;
    hdr_r <= hdr_mem[hdr_raddr];
    chr_r <= chr_mem[chr_raddr];
  end

  assign hdr_rdata = hdr_r;
  assign chr_rdata = chr_r;
endmodule

@@ rtl/core/serial_command_state_matcher.sv @@
// Top level: command intake, line scan sequencer, result register, APB registers.
//
// Input items (in_valid/in_ready) carry one command: a received byte, a table
// header write, an event character write, or a restart. Only a CR or LF byte
// yields a result item on out_valid/out_ready; all other commands yield none.
// A terminator walks the line store one character at a time to find the first
// token, runs a binary search over the entry headers, then compares event
// characters one at a time for each candidate entry. Each step issues a read
// and waits on the single registered read port of the line store or the table
// memories.
// One item is in work at a time; in_ready is low while a terminator is scanned.
// The result register holds a finished item while the receiver stalls; a new
// terminator then waits for the register to drain before its result is loaded.
// Reset (rst_n, synchronous) clears the line, the states, last match and both
// registers; table contents are undefined until written. Registers must be
// written over the APB port only while the block is idle; no logic enforces it.
module serial_command_state_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic [4:0]  in_entry_index,
  input  logic [7:0]  in_entry_state,
  input  logic [7:0]  in_entry_next,
  input  logic [4:0]  in_event_length,
  input  logic [3:0]  in_char_index,
  input  logic [7:0]  in_char_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_matched_index,
  output logic [7:0]  out_new_state,
  output logic [7:0]  out_previous_state,
  output logic [6:0]  out_token_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SKIP, S_SKIP_W, S_CNT, S_CNT_W, S_SEARCH, S_SEARCH_W,
    S_SCAN, S_SCAN_W, S_CMP, S_CMP_W, S_OUT
  } state_t;

  state_t              state_r;
  logic [7:0]          init_state_r;
  logic [5:0]          entry_count_r;
  logic [7:0]          cur_r, prior_r;
  logic [TBL_AW-1:0]   last_r;
  logic [LINE_AW:0]    tstart_r, tlen_r;
  logic [TBL_AW:0]     n_r, lo_r, hi_r, found_r, mid_r, idx_r;
  logic [4:0]          k_r;
  logic [7:0]          hit_next_r;
  logic [4:0]          hit_len_r;
  logic [1:0]          res_status_r;
  logic                out_valid_r;
  logic [1:0]          o_status_r;
  logic [4:0]          o_index_r;
  logic [7:0]          o_new_r, o_prev_r;
  logic [6:0]          o_tlen_r;

  line_wr_t            lwr;
  tbl_wr_t             twr;
  logic [LINE_AW-1:0]  line_raddr;
  logic [7:0]          line_rdata;
  logic [LINE_AW:0]    extent;
  logic [TBL_AW-1:0]   hdr_raddr;
  tbl_hdr_t            hdr_rdata;
  logic [7:0]          chr_rdata;
  logic [LINE_AW:0]    cnt_pos, cmp_pos;
  logic [TBL_AW:0]     mid_c;
  logic                accept, is_term, cfg_wr;

  assign accept  = in_valid && in_ready;
  assign is_term = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign in_ready = (state_r == S_IDLE);
  assign cnt_pos = tstart_r + tlen_r;
  assign cmp_pos = tstart_r + (LINE_AW + 1)'(k_r);
  assign mid_c   = lo_r + ((hi_r - lo_r - 1'b1) >> 1);

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {26'd0, entry_count_r}
                                                : {24'd0, init_state_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_state_r  <= '0;
      entry_count_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_INIT_STATE) init_state_r <= pwdata[7:0];
      else entry_count_r <= pwdata[5:0];
    end
  end

  // line buffer requests: store printable bytes, clear on restart or scan end (kept when no table is set)
  always_comb begin
    lwr.data = in_rx_byte;
    lwr.we   = accept && (in_command == CMD_BYTE) && !is_term &&
               (in_rx_byte >= CH_SPACE) && (in_rx_byte <= CH_TILDE);
    lwr.clr  = (accept && (in_command == CMD_RESTART)) ||
               (state_r == S_SCAN && idx_r >= n_r) ||
               (state_r == S_SCAN_W) && (hdr_rdata.state != cur_r ||
                                         hdr_rdata.len == '0) ||
               (state_r == S_CMP_W && fold_case(line_rdata) == fold_case(chr_rdata) &&
                k_r + 1'b1 == hit_len_r);
  end

  // table write requests
  always_comb begin
    twr.hdr_we = accept && (in_command == CMD_HEADER);
    twr.chr_we = accept && (in_command == CMD_CHAR);
    twr.idx    = in_entry_index;
    twr.state  = in_entry_state;
    twr.next   = in_entry_next;
    twr.len    = in_event_length;
    twr.cidx   = in_char_index;
    twr.cval   = in_char_value;
  end

  // read addresses per sequencer step
  always_comb begin
    case (state_r)
      S_CNT:   line_raddr = cnt_pos[LINE_AW-1:0];
      S_CMP:   line_raddr = cmp_pos[LINE_AW-1:0];
      default: line_raddr = tstart_r[LINE_AW-1:0];
    endcase
    hdr_raddr = (state_r == S_SEARCH) ? mid_c[TBL_AW-1:0] : idx_r[TBL_AW-1:0];
  end

  scm_line_buf u_line (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (lwr),
    .raddr  (line_raddr),
    .rdata  (line_rdata),
    .extent (extent)
  );

  scm_table u_tbl (
    .clk       (clk),
    .wr        (twr),
    .hdr_raddr (hdr_raddr),
    .hdr_rdata (hdr_rdata),
    .chr_raddr ({idx_r[TBL_AW-1:0], k_r[EV_AW-1:0]}),
    .chr_rdata (chr_rdata)
  );

  // sequencer: token scan, binary search, entry compare, result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      prior_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in the same cycle
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && in_command == CMD_RESTART) begin
            cur_r   <= init_state_r;
            prior_r <= init_state_r;
            last_r  <= '0;
          end else if (accept && in_command == CMD_BYTE && is_term) begin
            tstart_r <= '0;
            tlen_r   <= '0;
            n_r      <= (entry_count_r > 6'(TABLE_DEPTH)) ? (TBL_AW + 1)'(TABLE_DEPTH)
                                                         : (TBL_AW + 1)'(entry_count_r);
            state_r  <= S_SKIP;
          end
        end
        S_SKIP: state_r <= (tstart_r >= extent) ? S_SEARCH : S_SKIP_W;
        S_SKIP_W: begin
          if (line_rdata == CH_SPACE) begin
            tstart_r <= tstart_r + 1'b1;
            state_r  <= S_SKIP;
          end else begin
            tlen_r  <= (LINE_AW + 1)'(1);
            state_r <= S_CNT;
          end
        end
        S_CNT: state_r <= (cnt_pos >= extent) ? S_SEARCH : S_CNT_W;
        S_CNT_W: begin
          if (line_rdata == CH_SPACE) begin
            state_r <= S_SEARCH;
          end else begin
            tlen_r  <= tlen_r + 1'b1;
            state_r <= S_CNT;
          end
        end
        S_SEARCH: begin
          if (n_r == '0) begin
            res_status_r <= ST_NO_TABLE;
            state_r      <= S_OUT;
          end else if (lo_r < hi_r) begin
            mid_r   <= mid_c;
            state_r <= S_SEARCH_W;
          end else begin
            idx_r   <= found_r;
            state_r <= S_SCAN;
          end
        end
        S_SEARCH_W: begin
          if (cur_r > hdr_rdata.state) begin
            lo_r <= mid_r + 1'b1;
          end else if (cur_r < hdr_rdata.state) begin
            hi_r <= mid_r;
          end else begin
            found_r <= mid_r;
            hi_r    <= mid_r;
          end
          state_r <= S_SEARCH;
        end
        S_SCAN: begin
          if (idx_r >= n_r) begin
            res_status_r <= ST_NO_MATCH;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          hit_next_r <= hdr_rdata.next;
          hit_len_r  <= hdr_rdata.len;
          k_r        <= '0;
          if (hdr_rdata.state != cur_r) begin
            res_status_r <= ST_NO_MATCH;
            state_r      <= S_OUT;
          end else if (hdr_rdata.len == '0) begin
            last_r       <= idx_r[TBL_AW-1:0];
            prior_r      <= cur_r;
            cur_r        <= hdr_rdata.next;
            res_status_r <= ST_MATCH;
            state_r      <= S_OUT;
          end else if ((LINE_AW + 1)'(hdr_rdata.len) != tlen_r) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_CMP_W;
        S_CMP_W: begin
          if (fold_case(line_rdata) != fold_case(chr_rdata)) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end else if (k_r + 1'b1 == hit_len_r) begin
            last_r       <= idx_r[TBL_AW-1:0];
            prior_r      <= cur_r;
            cur_r        <= hit_next_r;
            res_status_r <= ST_MATCH;
            state_r      <= S_OUT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_CMP;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_status_r  <= res_status_r;
            o_index_r   <= last_r;
            o_new_r     <= cur_r;
            o_prev_r    <= prior_r;
            o_tlen_r    <= tlen_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // search bounds start fresh for each line
      if (state_r == S_IDLE) begin
        lo_r    <= '0;
        hi_r    <= (entry_count_r > 6'(TABLE_DEPTH)) ? (TBL_AW + 1)'(TABLE_DEPTH)
                                                    : (TBL_AW + 1)'(entry_count_r);
        found_r <= (entry_count_r > 6'(TABLE_DEPTH)) ? (TBL_AW + 1)'(TABLE_DEPTH)
                                                    : (TBL_AW + 1)'(entry_count_r);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_matched_index  = o_index_r;
  assign out_new_state      = o_new_r;
  assign out_previous_state = o_prev_r;
  assign out_token_length   = o_tlen_r;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_status_r == ST_MATCH || o_status_r == ST_NO_MATCH ||
                     o_status_r == ST_NO_TABLE))
    else $error("result carries an undefined status");
  a_extent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    extent <= (LINE_AW + 1)'(LINE_LEN))
    else $error("line extent beyond line length");
  a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_BYTE && is_term) |=> !in_ready)
    else $error("terminator did not start a scan");
  a_token_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (tstart_r + tlen_r <= extent))
    else $error("token runs past line extent");
`endif
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the serial command state matcher: queued driver, monitor, line predictor.
module tb_top;
  import scm_pkg::*;

  localparam int          CYCLE_LIMIT = 4000000;
  localparam int          SETTLE      = 40;
  localparam int          LONG_HOLD   = 400;
  localparam logic [2:0]  ADDR_INIT   = {REG_INIT_STATE, 2'b00};
  localparam logic [2:0]  ADDR_COUNT  = {REG_ENTRY_COUNT, 2'b00};

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] rx;
    logic [4:0] idx;
    logic [7:0] st;
    logic [7:0] nx;
    logic [4:0] len;
    logic [3:0] ci;
    logic [7:0] cv;
  } cmd_item_t;

  typedef struct {
    logic [1:0] status;
    logic [4:0] idx;
    logic [7:0] ns;
    logic [7:0] ps;
    logic [6:0] tl;
  } line_result_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_command;
  logic [7:0]  in_rx_byte;
  logic [4:0]  in_entry_index;
  logic [7:0]  in_entry_state;
  logic [7:0]  in_entry_next;
  logic [4:0]  in_event_length;
  logic [3:0]  in_char_index;
  logic [7:0]  in_char_value;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic [4:0]  out_matched_index;
  logic [7:0]  out_new_state;
  logic [7:0]  out_previous_state;
  logic [6:0]  out_token_length;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  serial_command_state_matcher DUT (.*);

  // queues and run control
  cmd_item_t    pending_q[$];
  line_result_t line_result_q[$];
  logic         in_fire;
  logic         quiet;
  logic         hold_req;
  int           hold_left, stall_left, gap_left;
  int           cycles, n_items, n_lines, n_restarts, n_err;

  // predictor copy of the block
  logic [7:0] cfg_init;
  logic [5:0] cfg_count;
  logic [7:0] p_line[LINE_LEN];
  int         p_wpos, p_extent;
  logic [7:0] p_cur, p_prior;
  logic [4:0] p_last;
  logic [7:0] p_est[TABLE_DEPTH];
  logic [7:0] p_enx[TABLE_DEPTH];
  logic [4:0] p_elen[TABLE_DEPTH];
  logic [7:0] p_ech[TABLE_DEPTH*EVENT_LEN];

  // stimulus word pool
  string pool[4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] lower_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void wipe_line();
    for (int k = 0; k < LINE_LEN; k++) p_line[k] = 8'h00;
    p_wpos = 0;
    p_extent = 0;
  endfunction

  // lowest index holding state s, found by the block's binary search
  function automatic int first_of_state(int n, logic [7:0] s);
    int lo, hi, mid, found;
    lo = 0;
    hi = n;
    found = n;
    while (lo < hi) begin
      mid = lo + (hi - lo - 1) / 2;
      if (s > p_est[mid]) lo = mid + 1;
      else if (s < p_est[mid]) hi = mid;
      else begin
        found = mid;
        hi = mid;
      end
    end
    return found;
  endfunction

  function automatic bit word_hits(int e, int ts, int tl);
    int el;
    el = p_elen[e];
    if (el == 0) return 1'b1;
    if (tl != el) return 1'b0;
    for (int k = 0; k < el; k++)
      if (lower_char(p_line[ts+k]) != lower_char(p_ech[e*EVENT_LEN+k])) return 1'b0;
    return 1'b1;
  endfunction

  // resolve a terminated line into its result
  function automatic line_result_t close_line();
    line_result_t r;
    int ts, tl, n, i;
    ts = 0;
    tl = 0;
    while (ts < p_extent && p_line[ts] == CH_SPACE) ts++;
    while (ts + tl < p_extent && p_line[ts+tl] != CH_SPACE) tl++;
    n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
    r.status = ST_NO_MATCH;
    if (n == 0) begin
      r.status = ST_NO_TABLE;
    end else begin
      i = first_of_state(n, p_cur);
      while (i < n && p_est[i] == p_cur) begin
        if (word_hits(i, ts, tl)) begin
          p_last = i[4:0];
          p_prior = p_cur;
          p_cur = p_enx[i];
          r.status = ST_MATCH;
          break;
        end
        i++;
      end
      wipe_line();
    end
    r.idx = p_last;
    r.ns = p_cur;
    r.ps = p_prior;
    r.tl = tl[6:0];
    return r;
  endfunction

  // advance the predictor by one accepted item
  function automatic void predict_item(cmd_item_t it);
    int l;
    case (it.cmd)
      CMD_BYTE: begin
        if (it.rx == CH_CR || it.rx == CH_LF) begin
          line_result_q.push_back(close_line());
        end else if (it.rx >= CH_SPACE && it.rx <= CH_TILDE) begin
          p_line[p_wpos] = it.rx;
          p_wpos++;
          if (p_wpos > p_extent) p_extent = p_wpos;
          if (p_wpos >= LINE_LEN) p_wpos = 0;
        end
      end
      CMD_HEADER: begin
        l = (it.len > EVENT_LEN) ? EVENT_LEN : it.len;
        p_est[it.idx] = it.st;
        p_enx[it.idx] = it.nx;
        p_elen[it.idx] = l[4:0];
      end
      CMD_CHAR: p_ech[it.idx*EVENT_LEN+it.ci] = it.cv;
      default: begin
        p_cur = cfg_init;
        p_prior = cfg_init;
        p_last = '0;
        wipe_line();
      end
    endcase
  endfunction

  // item builders: unused fields carry random values
  function automatic cmd_item_t rand_item(logic [1:0] c);
    cmd_item_t it;
    it.cmd = c;
    it.rx = $urandom;
    it.idx = $urandom;
    it.st = $urandom;
    it.nx = $urandom;
    it.len = $urandom;
    it.ci = $urandom;
    it.cv = $urandom;
    return it;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    cmd_item_t it;
    it = rand_item(CMD_BYTE);
    it.rx = b;
    pending_q.push_back(it);
  endfunction

  function automatic void push_restart();
    pending_q.push_back(rand_item(CMD_RESTART));
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  // load one entry: its event characters, then the header
  function automatic void push_entry(int e, logic [7:0] s, logic [7:0] nx, string w);
    cmd_item_t it;
    for (int k = 0; k < w.len(); k++) begin
      it = rand_item(CMD_CHAR);
      it.idx = e;
      it.ci = k;
      it.cv = flip_case(w[k]);
      pending_q.push_back(it);
    end
    it = rand_item(CMD_HEADER);
    it.idx = e;
    it.st = s;
    it.nx = nx;
    it.len = (w.len() == EVENT_LEN && $urandom_range(0, 1)) ? $urandom_range(17, 31) : w.len();
    pending_q.push_back(it);
  endfunction

  // fill all entries; sorted groups of four per state, or scattered states
  function automatic void load_table(int base, bit scattered);
    for (int e = 0; e < TABLE_DEPTH; e++)
      push_entry(e, scattered ? base + $urandom_range(0, 3) : base + e / 4,
                 base + $urandom_range(0, 7), pool[e%4]);
  endfunction

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(flip_case(s[k]));
  endfunction

  function automatic void push_eol();
    push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endfunction

  // one random line, mostly words the table knows
  function automatic void push_rand_line();
    int kind;
    kind = $urandom_range(0, 15);
    repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
    case (kind)
      0: ;
      1: repeat ($urandom_range(1, 8)) push_byte($urandom);
      2: repeat ($urandom_range(60, 80)) push_byte($urandom_range(8'h21, 8'h7E));
      3: repeat ($urandom_range(1, 5)) push_byte($urandom_range(8'h21, 8'h7E));
      default: push_text(pool[$urandom_range(0, 3)]);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      push_byte(CH_SPACE);
      repeat ($urandom_range(1, 4)) push_byte($urandom_range(8'h20, 8'h7E));
    end
    if ($urandom_range(0, 7) == 0) push_byte($urandom_range(0, 1) ? 8'h7F : 8'h05);
    push_eol();
    if ($urandom_range(0, 29) == 0) push_restart();
  endfunction

  function automatic void push_lines(int n);
    repeat (n) push_rand_line();
  endfunction

  // register write over APB, setup then access
  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (a == ADDR_INIT) cfg_init = d[7:0];
    else cfg_count = d[5:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the sender until every expected result is back and the block is idle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || line_result_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        cmd_item_t it;
        it = pending_q.pop_front();
        in_command <= it.cmd;
        in_rx_byte <= it.rx;
        in_entry_index <= it.idx;
        in_entry_state <= it.st;
        in_entry_next <= it.nx;
        in_event_length <= it.len;
        in_char_index <= it.ci;
        in_char_value <= it.cv;
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: long hold on request, else short stall bursts
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results, then predict from accepted items
  always @(posedge clk) begin
    cycles++;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (line_result_q.size() == 0) begin
          $error("result with no line pending: status %0d", out_status);
          n_err++;
        end else begin
          line_result_t r;
          r = line_result_q.pop_front();
          n_lines++;
          if (out_status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, out_status);
            n_err++;
          end
          if (out_matched_index !== r.idx) begin
            $error("matched_index: expected %0d, got %0d", r.idx, out_matched_index);
            n_err++;
          end
          if (out_new_state !== r.ns) begin
            $error("new_state: expected %0d, got %0d", r.ns, out_new_state);
            n_err++;
          end
          if (out_previous_state !== r.ps) begin
            $error("previous_state: expected %0d, got %0d", r.ps, out_previous_state);
            n_err++;
          end
          if (out_token_length !== r.tl) begin
            $error("token_length: expected %0d, got %0d", r.tl, out_token_length);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) begin
        cmd_item_t it;
        it.cmd = in_command;
        it.rx = in_rx_byte;
        it.idx = in_entry_index;
        it.st = in_entry_state;
        it.nx = in_entry_next;
        it.len = in_event_length;
        it.ci = in_char_index;
        it.cv = in_char_value;
        n_items++;
        if (it.cmd == CMD_RESTART) n_restarts++;
        predict_item(it);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines outstanding", cycles,
               line_result_q.size());
      $display("serial_command_state_matcher test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_BYTE;
    in_rx_byte = '0;
    in_entry_index = '0;
    in_entry_state = '0;
    in_entry_next = '0;
    in_event_length = '0;
    in_char_index = '0;
    in_char_value = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_fire = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    gap_left = 0;
    cycles = 0;
    n_items = 0;
    n_lines = 0;
    n_restarts = 0;
    n_err = 0;
    cfg_init = '0;
    cfg_count = '0;
    p_cur = '0;
    p_prior = '0;
    p_last = '0;
    wipe_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no table: filtered bytes, terminator keeps the line, then restart
    push_byte(8'h00);
    push_byte(8'h1F);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_byte(CH_TILDE);
    push_text("Go");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_restart();
    drain();

    // small sorted table, boundary characters around the letter range
    pool[0] = "go";
    pool[1] = "Zap@[`{";
    pool[2] = "abcdefghijklmnop";
    pool[3] = "";
    load_table(0, 1'b0);
    drain();
    reg_write(ADDR_COUNT, 8);
    reg_write(ADDR_INIT, 0);
    push_restart();
    push_text("  GO args");
    push_eol();
    push_text("zAP@[`{");
    push_eol();
    push_text("goo");
    push_eol();
    push_eol();
    push_text("ABCDEFGHIJKLMNOP");
    push_eol();
    repeat (70) push_byte("q");
    push_eol();
    drain();

    // full sorted table, mid initial state
    reg_write(ADDR_COUNT, TABLE_DEPTH);
    reg_write(ADDR_INIT, 2);
    push_restart();
    push_lines(8);
    drain();

    // oversize count, new words; receiver holds while the sender keeps going
    pool[0] = "STOP";
    pool[1] = "x";
    pool[2] = "Run9";
    pool[3] = "";
    load_table(248, 1'b0);
    drain();
    reg_write(ADDR_COUNT, 63);
    reg_write(ADDR_INIT, 255);
    push_restart();
    push_lines(12);
    hold_req = 1'b1;
    drain();

    // single entry, then a few, from the lowest state
    reg_write(ADDR_COUNT, 1);
    reg_write(ADDR_INIT, 248);
    push_restart();
    push_lines(5);
    drain();
    reg_write(ADDR_COUNT, 5);
    push_lines(5);
    drain();

    // scattered states, random count
    load_table($urandom_range(0, 252), 1'b1);
    drain();
    reg_write(ADDR_COUNT, $urandom_range(1, TABLE_DEPTH));
    reg_write(ADDR_INIT, p_est[$urandom_range(0, 3)]);
    push_restart();
    push_lines(8);
    drain();

    // closing stretch with no idling, table switched off
    quiet = 1'b1;
    reg_write(ADDR_COUNT, 0);
    reg_write(ADDR_INIT, 0);
    push_restart();
    push_lines(4);
    drain();

    $display("covered %0d items, %0d restarts, %0d line results checked", n_items,
             n_restarts, n_lines);
    $display("configs: empty, single, partial, full and oversize tables; %0d mismatches",
             n_err);
    if (n_err == 0) begin
      $display("serial_command_state_matcher test passed");
    end else begin
      $display("serial_command_state_matcher test failed");
    end
    $finish;
  end

endmodule
